/* src/ertm_pkg.sv */
// Shared constants, types and helper functions for the Euler-angle to rotation-matrix block.
// Used by euler_to_rotation_matrix and its checker; depends on nothing else.
package ertm_pkg;

    localparam int ANGLE_FRAC_BITS_DEF   = 13;
    localparam int SINCOS_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES          = 24;

    // Widths: angle reduction word, CORDIC word, product word, sum word.
    localparam int ZW = 40;
    localparam int CW = 34;
    localparam int PW = 68;
    localparam int SW = 69;
    localparam int KW = 6;

    localparam longint Q30_PI       = 64'sd3373259426;
    localparam longint Q30_HALF_PI  = 64'sd1686629713;
    localparam longint Q30_TWO_PI   = 64'sd6746518852;
    localparam longint Q30_INV_GAIN = 64'sd652032874;
    localparam int     OUT_MAX      = 16384;

    typedef logic signed [ZW-1:0] zval_t;
    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [15:0]   q14_t;

    function automatic cval_t atan_q30(input int unsigned idx);
        cval_t v;
        case (idx)
            0:       v = CW'(34'sh03243F6A8);
            1:       v = CW'(34'sh01DAC6705);
            2:       v = CW'(34'sh00FADBAFC);
            3:       v = CW'(34'sh007F56EA6);
            4:       v = CW'(34'sh003FEAB76);
            5:       v = CW'(34'sh001FFD55B);
            6:       v = CW'(34'sh000FFFAAA);
            7:       v = CW'(34'sh0007FFF55);
            8:       v = CW'(34'sh0003FFFEA);
            9:       v = CW'(34'sh0001FFFFD);
            10:      v = CW'(34'sh0000FFFFF);
            11:      v = CW'(34'sh00007FFFF);
            12:      v = CW'(34'sh00003FFFF);
            13:      v = CW'(34'sh00001FFFF);
            14:      v = CW'(34'sh00000FFFF);
            15:      v = CW'(34'sh000007FFF);
            16:      v = CW'(34'sh000003FFF);
            17:      v = CW'(34'sh000001FFF);
            18:      v = CW'(34'sh000000FFF);
            19:      v = CW'(34'sh0000007FF);
            20:      v = CW'(34'sh0000003FF);
            21:      v = CW'(34'sh0000001FF);
            22:      v = CW'(34'sh0000000FF);
            23:      v = CW'(34'sh00000007F);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a Q60 sum to Q14 and clamp to plus or minus one.
    function automatic q14_t to_q14(input logic signed [SW-1:0] q60);
        logic signed [SW-1:0] t;
        logic signed [SW-47:0] v;
        q14_t r;
        t = q60 + (SW'(1) <<< 45);
        v = t[SW-1:46];
        if (v > (SW-46)'(OUT_MAX))
            r = 16'(OUT_MAX);
        else if (v < -(SW-46)'(OUT_MAX))
            r = -16'(OUT_MAX);
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* src/euler_to_rotation_matrix.sv */
// Top level: Euler angles (Z-Y-X) to a 3x3 rotation matrix, fully pipelined.
// Depends on ertm_pkg for constants, the arctangent table and output rounding.
//
//  channel   handshake         payload
//  input     start / busy      angle_x angle_y angle_z (signed, ANGLE_FRAC_BITS fraction)
//  result    done (strobe)     m00 m01 m02 m10 m11 m12 m20 m21 m22 (signed Q1.14)
//
// One transfer is taken every cycle; busy stays low. Each input passes through
// four angle-reduction stages, one CORDIC stage per iteration, a sign stage and
// three product stages.
// Reset clears only the valid bits that travel with the data.
// The receiver cannot stall, so the pipeline never holds.
module euler_to_rotation_matrix #(
    parameter int ANGLE_FRAC_BITS   = ertm_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int SINCOS_ITERATIONS = ertm_pkg::SINCOS_ITERATIONS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    output logic               done,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    localparam int NI  = (SINCOS_ITERATIONS > ertm_pkg::ATAN_ENTRIES) ?
                         ertm_pkg::ATAN_ENTRIES : SINCOS_ITERATIONS;
    localparam int SH  = 30 - ANGLE_FRAC_BITS;
    localparam int KB  = 40;
    localparam longint RECIP = ((64'sd1 <<< (SH + KB)) + ertm_pkg::Q30_TWO_PI / 2)
                               / ertm_pkg::Q30_TWO_PI;
    localparam int LAT = 8 + NI;
    localparam int MW  = 48;

    localparam ertm_pkg::zval_t ZPI      = ertm_pkg::ZW'(ertm_pkg::Q30_PI);
    localparam ertm_pkg::zval_t ZHALF_PI = ertm_pkg::ZW'(ertm_pkg::Q30_HALF_PI);
    localparam ertm_pkg::zval_t ZTWO_PI  = ertm_pkg::ZW'(ertm_pkg::Q30_TWO_PI);
    localparam logic signed [MW-1:0] RECIP_M = MW'(RECIP);

    logic [LAT-1:0] vld_reg;

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
    end

    logic signed [15:0] ang [3];
    assign ang[0] = angle_x;
    assign ang[1] = angle_y;
    assign ang[2] = angle_z;

    // Lane 0 is x, lane 1 is y, lane 2 is z.
    logic signed [15:0]     a1_reg [3];
    logic signed [MW-1:0]   q1_reg [3];
    ertm_pkg::zval_t        r2_reg [3];
    ertm_pkg::zval_t        r3_reg [3];
    ertm_pkg::cval_t        cx_reg [NI+1][3];
    ertm_pkg::cval_t        cy_reg [NI+1][3];
    ertm_pkg::cval_t        cz_reg [NI+1][3];
    logic                   fl_reg [NI+1][3];
    ertm_pkg::cval_t        s_reg  [3];
    ertm_pkg::cval_t        c_reg  [3];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [MW-1:0]       q_round;
        logic signed [ertm_pkg::KW-1:0] k;
        ertm_pkg::zval_t            z_in;
        ertm_pkg::zval_t            r_next;
        ertm_pkg::zval_t            rc_next;
        ertm_pkg::zval_t            rf_next;
        logic                       fl_next;

        // Quotient estimate by 1/(2*pi); it can miss by one near a tie,
        // which the next stage corrects.
        assign q_round = q1_reg[l] + (MW'(1) <<< (KB - 1));
        assign k       = q_round[KB+ertm_pkg::KW-1:KB];
        assign z_in    = ertm_pkg::ZW'(a1_reg[l]) <<< SH;
        assign r_next  = z_in - ertm_pkg::ZW'(k) * ZTWO_PI;

        always_comb
        begin
            if (r2_reg[l] > ZPI)
                rc_next = r2_reg[l] - ZTWO_PI;
            else if (r2_reg[l] < -ZPI)
                rc_next = r2_reg[l] + ZTWO_PI;
            else
                rc_next = r2_reg[l];
        end

        always_comb
        begin
            if (r3_reg[l] > ZHALF_PI)
            begin
                rf_next = r3_reg[l] - ZPI;
                fl_next = 1'b1;
            end
            else if (r3_reg[l] < -ZHALF_PI)
            begin
                rf_next = r3_reg[l] + ZPI;
                fl_next = 1'b1;
            end
            else
            begin
                rf_next = r3_reg[l];
                fl_next = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            a1_reg[l]    <= ang[l];
            q1_reg[l]    <= MW'(ang[l]) * RECIP_M;
            r2_reg[l]    <= r_next;
            r3_reg[l]    <= rc_next;
            cz_reg[0][l] <= ertm_pkg::CW'(rf_next);
            cx_reg[0][l] <= ertm_pkg::CW'(ertm_pkg::Q30_INV_GAIN);
            cy_reg[0][l] <= '0;
            fl_reg[0][l] <= fl_next;
        end

        for (genvar i = 0; i < NI; i++) begin : g_iter
            localparam ertm_pkg::cval_t ATAN_I = ertm_pkg::atan_q30(i);
            always_ff @(posedge clk)
            begin
                if (!cz_reg[i][l][ertm_pkg::CW-1])
                begin
                    cx_reg[i+1][l] <= cx_reg[i][l] - (cy_reg[i][l] >>> i);
                    cy_reg[i+1][l] <= cy_reg[i][l] + (cx_reg[i][l] >>> i);
                    cz_reg[i+1][l] <= cz_reg[i][l] - ATAN_I;
                end
                else
                begin
                    cx_reg[i+1][l] <= cx_reg[i][l] + (cy_reg[i][l] >>> i);
                    cy_reg[i+1][l] <= cy_reg[i][l] - (cx_reg[i][l] >>> i);
                    cz_reg[i+1][l] <= cz_reg[i][l] + ATAN_I;
                end
                fl_reg[i+1][l] <= fl_reg[i][l];
            end
        end

        always_ff @(posedge clk)
        begin
            s_reg[l] <= fl_reg[NI][l] ? -cy_reg[NI][l] : cy_reg[NI][l];
            c_reg[l] <= fl_reg[NI][l] ? -cx_reg[NI][l] : cx_reg[NI][l];
        end
    end

    // First product stage.
    ertm_pkg::cval_t czsy_reg, szsy_reg, sx1_reg, cx1_reg, sz1_reg, cz1_reg, sy1_reg;
    ertm_pkg::prod_t p00_reg, p10_reg, p21_reg, p22_reg;
    ertm_pkg::prod_t czsy_p, szsy_p;

    assign czsy_p = ertm_pkg::PW'(c_reg[2]) * ertm_pkg::PW'(s_reg[1])
                    + (ertm_pkg::PW'(1) <<< 29);
    assign szsy_p = ertm_pkg::PW'(s_reg[2]) * ertm_pkg::PW'(s_reg[1])
                    + (ertm_pkg::PW'(1) <<< 29);

    always_ff @(posedge clk)
    begin
        czsy_reg <= czsy_p[30+ertm_pkg::CW-1:30];
        szsy_reg <= szsy_p[30+ertm_pkg::CW-1:30];
        p00_reg  <= ertm_pkg::PW'(c_reg[2]) * ertm_pkg::PW'(c_reg[1]);
        p10_reg  <= ertm_pkg::PW'(s_reg[2]) * ertm_pkg::PW'(c_reg[1]);
        p21_reg  <= ertm_pkg::PW'(c_reg[1]) * ertm_pkg::PW'(s_reg[0]);
        p22_reg  <= ertm_pkg::PW'(c_reg[1]) * ertm_pkg::PW'(c_reg[0]);
        sx1_reg  <= s_reg[0];
        cx1_reg  <= c_reg[0];
        sy1_reg  <= s_reg[1];
        sz1_reg  <= s_reg[2];
        cz1_reg  <= c_reg[2];
    end

    // Second product stage.
    ertm_pkg::prod_t a1p_reg, a2p_reg, b1p_reg, b2p_reg, c1p_reg, c2p_reg, d1p_reg, d2p_reg;
    ertm_pkg::prod_t p00b_reg, p10b_reg, p21b_reg, p22b_reg;
    ertm_pkg::cval_t sy2_reg;

    always_ff @(posedge clk)
    begin
        a1p_reg  <= ertm_pkg::PW'(czsy_reg) * ertm_pkg::PW'(sx1_reg);
        a2p_reg  <= ertm_pkg::PW'(sz1_reg) * ertm_pkg::PW'(cx1_reg);
        b1p_reg  <= ertm_pkg::PW'(czsy_reg) * ertm_pkg::PW'(cx1_reg);
        b2p_reg  <= ertm_pkg::PW'(sz1_reg) * ertm_pkg::PW'(sx1_reg);
        c1p_reg  <= ertm_pkg::PW'(szsy_reg) * ertm_pkg::PW'(sx1_reg);
        c2p_reg  <= ertm_pkg::PW'(cz1_reg) * ertm_pkg::PW'(cx1_reg);
        d1p_reg  <= ertm_pkg::PW'(szsy_reg) * ertm_pkg::PW'(cx1_reg);
        d2p_reg  <= ertm_pkg::PW'(cz1_reg) * ertm_pkg::PW'(sx1_reg);
        p00b_reg <= p00_reg;
        p10b_reg <= p10_reg;
        p21b_reg <= p21_reg;
        p22b_reg <= p22_reg;
        sy2_reg  <= sy1_reg;
    end

    // Sums, rounding and clamping into the output registers.
    typedef struct packed {
        logic signed [15:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    } q14_regs_t;
    q14_regs_t out_reg;

    always_ff @(posedge clk)
    begin
        out_reg.e00 <= ertm_pkg::to_q14(ertm_pkg::SW'(p00b_reg));
        out_reg.e01 <= ertm_pkg::to_q14(ertm_pkg::SW'(a1p_reg) - ertm_pkg::SW'(a2p_reg));
        out_reg.e02 <= ertm_pkg::to_q14(ertm_pkg::SW'(b1p_reg) + ertm_pkg::SW'(b2p_reg));
        out_reg.e10 <= ertm_pkg::to_q14(ertm_pkg::SW'(p10b_reg));
        out_reg.e11 <= ertm_pkg::to_q14(ertm_pkg::SW'(c1p_reg) + ertm_pkg::SW'(c2p_reg));
        out_reg.e12 <= ertm_pkg::to_q14(ertm_pkg::SW'(d1p_reg) - ertm_pkg::SW'(d2p_reg));
        out_reg.e20 <= ertm_pkg::to_q14(-(ertm_pkg::SW'(sy2_reg) <<< 30));
        out_reg.e21 <= ertm_pkg::to_q14(ertm_pkg::SW'(p21b_reg));
        out_reg.e22 <= ertm_pkg::to_q14(ertm_pkg::SW'(p22b_reg));
    end

    assign m00 = out_reg.e00;
    assign m01 = out_reg.e01;
    assign m02 = out_reg.e02;
    assign m10 = out_reg.e10;
    assign m11 = out_reg.e11;
    assign m12 = out_reg.e12;
    assign m20 = out_reg.e20;
    assign m21 = out_reg.e21;
    assign m22 = out_reg.e22;

endmodule

/* src/ertm_checker.sv */
// Port-level checker for euler_to_rotation_matrix and the bind that attaches it.
// Depends on ertm_pkg for the output limit.
module ertm_checker #(
    parameter int LAT = 24
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] m00,
    input logic signed [15:0] m20,
    input logic signed [15:0] m22
);

    localparam logic signed [15:0] LIM = 16'(ertm_pkg::OUT_MAX);

    // Every accepted transfer yields exactly one result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transfer produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching transfer");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (m00 <= LIM && m00 >= -LIM && m20 <= LIM && m20 >= -LIM
                  && m22 <= LIM && m22 >= -LIM))
        else $error("matrix entry beyond plus or minus one");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind euler_to_rotation_matrix ertm_checker #(.LAT(LAT)) u_ertm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .m00   (m00),
    .m20   (m20),
    .m22   (m22)
);
